// File: sv/ios_pkg.sv
// ----------------------------------------------------------------------------
// ios_pkg: shared types and constants for the insertion ordered set
// Word layouts, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package ios_pkg;

  // Default table depth and stored key width
  localparam int DEPTH_DEF    = 64;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths of the channel words
  localparam int KEY_W     = 32;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;

  // Operation codes
  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_READ     = 2'd3
  } ios_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP_ABSNT = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } ios_status_t;

  // Input word
  typedef struct packed {
    ios_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;
  } ios_in_t;

  // Result word
  typedef struct packed {
    ios_status_t          status;
    logic [KEY_W-1:0]     read_key;
    logic [CNT_OUT_W-1:0] entry_count;
  } ios_out_t;

endpackage

// File: sv/ios_ram.sv
// ----------------------------------------------------------------------------
// ios_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ios_ram #(
  parameter int WIDTH = ios_pkg::KEY_BITS_DEF,
  parameter int DEPTH = ios_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/insertion_ordered_set.sv
// ----------------------------------------------------------------------------
// insertion_ordered_set: set of distinct nonzero keys in insertion order
// Keys are packed at the front of a table RAM; a sequencer walks the table
// one entry per cycle through a single key comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_word and raise start; the word is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the operation has finished.
//   Result channel: out_valid is high for exactly one cycle with out_word;
//   the receiver cannot stall and must take the word in that cycle.
//   Path from accept to result:
//     zero key or bad position      result registered straight from idle
//     read at position              one RAM read in S_READ
//     add, contains                 one RAM read per held entry through
//                                   the comparator, until hit or last
//     remove                        search to the key, then one read and
//                                   one write per later entry
//   One operation is in flight at a time; the next may start in the cycle
//   its predecessor's result appears.
//   Reset clears the count at once; table contents are never read before
//   they are written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module insertion_ordered_set #(
  parameter int DEPTH    = ios_pkg::DEPTH_DEF,
  parameter int KEY_BITS = ios_pkg::KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ios_pkg::ios_in_t in_word,
  output logic             out_valid,
  output ios_pkg::ios_out_t out_word
);

  import ios_pkg::*;

  // Stored key width: the key field never carries more than KEY_W bits
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT
  } state_t;

  state_t               state_r, state_nxt;
  ios_kind_t            kind_r, kind_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ios_status_t          status_r, status_nxt;
  logic [KEY_W-1:0]     rkey_r, rkey_nxt;
  logic [CNT_OUT_W-1:0] ocnt_r, ocnt_nxt;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;

  // Derived values
  logic [KW-1:0]          key_m;
  logic [AW+POS_W-1:0]    pos_ext;
  logic                   pos_ok;
  logic [CW-1:0]          idx_inc;
  logic [CW-1:0]          idx_inc2;
  logic                   hit;
  logic                   last;
  logic [KEY_W+KW-1:0]    rdata_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  ios_ram #(
    .WIDTH(KW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Mask the key, widen the position and the walk index
  assign key_m     = in_word.key[KW-1:0];
  assign pos_ext   = {{AW{1'b0}}, in_word.position};
  assign pos_ok    = ({{CW{1'b0}}, in_word.position} < {{POS_W{1'b0}}, count_r});
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign idx_inc2  = CW'(idx_r) + CW'(2);
  assign hit       = (ram_rdata == key_r);
  assign last      = (idx_inc == count_r);
  assign rdata_ext = {{KEY_W{1'b0}}, ram_rdata};
  assign cnt_ext   = {{CNT_OUT_W{1'b0}}, count_nxt};

  // Sequencer: positional read, search, shift and append, with the one comparator
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    rkey_nxt      = '0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = key_r;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_word.kind;
          key_nxt  = key_m;
          idx_nxt  = '0;
          if (in_word.kind == KIND_READ) begin
            if (pos_ok) begin
              ram_raddr = pos_ext[AW-1:0];
              state_nxt = S_READ;
            end else begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_INVALID;
            end
          end else if (key_m == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_INVALID;
          end else if (count_r == '0) begin
            // Empty table: nothing to search
            out_valid_nxt = 1'b1;
            if (in_word.kind == KIND_ADD) begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = key_m;
              count_nxt  = CW'(1);
              status_nxt = ST_OK;
            end else begin
              status_nxt = ST_DUP_ABSNT;
            end
          end else begin
            ram_raddr = '0;
            state_nxt = S_SEARCH;
          end
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        rkey_nxt      = rdata_ext[KEY_W-1:0];
        state_nxt     = S_IDLE;
      end

      S_SEARCH: begin
        // Prefetch the next entry while comparing this one
        ram_raddr = idx_inc[AW-1:0];
        if (hit) begin
          unique case (kind_r) inside
            KIND_ADD: begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_DUP_ABSNT;
              state_nxt     = S_IDLE;
            end
            KIND_REMOVE: begin
              if (last) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_OK;
                count_nxt     = count_r - CW'(1);
                state_nxt     = S_IDLE;
              end else begin
                state_nxt = S_SHIFT;
              end
            end
            KIND_CONTAINS, KIND_READ: begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_OK;
              state_nxt     = S_IDLE;
            end
          endcase
        end else if (last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (kind_r == KIND_ADD) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count_r[AW-1:0];
              ram_wdata  = key_r;
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_OK;
            end
          end else begin
            status_nxt = ST_DUP_ABSNT;
          end
        end else begin
          idx_nxt = idx_inc[AW-1:0];
        end
      end

      S_SHIFT: begin
        // Move the entry above down one place, fetch the one after it
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        ram_raddr = idx_inc2[AW-1:0];
        idx_nxt   = idx_inc[AW-1:0];
        if (idx_inc2 == count_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          count_nxt     = count_r - CW'(1);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ocnt_nxt = cnt_ext[CNT_OUT_W-1:0];
  end

  // Hold state and registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    if (out_valid_nxt) begin
      status_r <= status_nxt;
      rkey_r   <= rkey_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_word.status      = status_r;
  assign out_word.read_key    = rkey_r;
  assign out_word.entry_count = ocnt_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while operation still running");

  a_count_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid)
    else $error("entry count changed without a result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r + CW'(1) == $past(count_r)))
    else $error("entry count moved by more than one");

  a_read_key_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.read_key != '0)) |-> (out_word.status == ST_OK))
    else $error("nonzero read key with failing status");
`endif

endmodule
